>>> rtl/core/npps_pkg.sv
// shared types and constants for the priority scheduler core
`timescale 1ns / 1ps
package npps_pkg;

  localparam int MAX_PROCESSES = 16;
  localparam int IDX_W = $clog2(MAX_PROCESSES);
  localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

  typedef struct packed {
    logic [15:0] arrival_time;
    logic [15:0] burst_time;
    logic [7:0]  job_priority;
    logic        last_job;
  } job_in_t;

  typedef struct packed {
    logic [3:0]  job_index;
    logic [23:0] completion_time;
    logic        last_result;
  } result_t;

  // running best pick and earliest pending arrival along the cell row
  typedef struct packed {
    logic             best_ok;
    logic [7:0]       best_prio;
    logic [IDX_W-1:0] best_idx;
    logic [15:0]      best_burst;
    logic             min_ok;
    logic [15:0]      min_arr;
  } chain_t;

endpackage

>>> rtl/core/npps_cell.sv
// one job cell: holds a record and folds it into the passing pick
`timescale 1ns / 1ps
module npps_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [npps_pkg::IDX_W-1:0] idx,
  input  logic                    valid,
  input  logic                    wr_en,
  input  npps_pkg::job_in_t       wr_data,
  input  logic                    clear_done,
  input  logic                    set_done,
  input  logic [npps_pkg::IDX_W-1:0] set_idx,
  input  logic [23:0]             cur_time,
  input  npps_pkg::chain_t        left,
  output npps_pkg::chain_t        right
);
  import npps_pkg::*;

  logic [15:0] arrival;
  logic [15:0] burst;
  logic [7:0]  prio;
  logic        done;
  logic        ready;
  logic        pend;
  chain_t      right_next;

  // record storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      arrival <= wr_data.arrival_time;
      burst   <= wr_data.burst_time;
      prio    <= wr_data.job_priority;
    end
  end

  // done flag
  always_ff @(posedge clk) begin
    if (rst || clear_done) begin
      done <= 1'b0;
    end else if (set_done && set_idx == idx) begin
      done <= 1'b1;
    end
  end

  // fold own record into the incoming candidate
  always_comb begin
    pend  = valid && !done;
    ready = pend && ({8'd0, arrival} <= cur_time);
    right_next = left;
    if (ready && (!left.best_ok || prio > left.best_prio)) begin
      right_next.best_ok    = 1'b1;
      right_next.best_prio  = prio;
      right_next.best_idx   = idx;
      right_next.best_burst = burst;
    end
    if (pend && (!left.min_ok || arrival < left.min_arr)) begin
      right_next.min_ok  = 1'b1;
      right_next.min_arr = arrival;
    end
  end

  always_ff @(posedge clk) begin
    right <= right_next;
  end

endmodule

>>> rtl/core/nonpreemptive_priority_scheduler_core.sv
// top level: job loading, cell row and schedule sequencer
//
//  channel   signals                  direction  handshake
//  job in    start, busy, job_in      in         start && !busy
//  result    result_valid, result     out        strobe, one cycle
//
// Records load one per cycle while idle. After the record marked last, the
// sequencer lets the cell row settle for the earliest arrival, then lets it
// settle again for each pick (plus one more settle when time jumps to the
// next arrival). busy is high during the run.
// Synchronous reset clears the job count, done flags and sequencer.
// Results are strobed for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
module nonpreemptive_priority_scheduler_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  npps_pkg::job_in_t job_in,
  output logic              busy,
  output logic              result_valid,
  output npps_pkg::result_t result
);
  import npps_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MIN, S_PICK} state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] settle;
  logic [CNT_W-1:0] picked;
  logic [23:0]      cur_time;
  logic             accept;
  logic             settled;
  logic             pick_fire;
  chain_t           chain [0:MAX_PROCESSES];

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign settled   = (settle == CNT_W'(MAX_PROCESSES));
  assign pick_fire = (state == S_PICK) && settled && chain[MAX_PROCESSES].best_ok;
  assign chain[0]  = '0;

  // row of job cells
  for (genvar i = 0; i < MAX_PROCESSES; i++) begin : g_cell
    npps_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .idx        (IDX_W'(i)),
      .valid      (CNT_W'(i) < count),
      .wr_en      (accept && count < CNT_W'(MAX_PROCESSES)
                   && count[IDX_W-1:0] == IDX_W'(i)),
      .wr_data    (job_in),
      .clear_done (accept && job_in.last_job),
      .set_done   (pick_fire),
      .set_idx    (chain[MAX_PROCESSES].best_idx),
      .cur_time   (cur_time),
      .left       (chain[i]),
      .right      (chain[i+1])
    );
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      settle       <= '0;
      picked       <= '0;
      cur_time     <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (!settled) begin
        settle <= settle + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (count < CNT_W'(MAX_PROCESSES)) begin
              count <= count + 1'b1;
            end
            if (job_in.last_job) begin
              state  <= S_MIN;
              settle <= '0;
              picked <= '0;
            end
          end
        end
        S_MIN: begin
          if (settled) begin
            if (chain[MAX_PROCESSES].min_ok) begin
              cur_time <= {8'd0, chain[MAX_PROCESSES].min_arr};
              state    <= S_PICK;
              settle   <= '0;
            end else begin
              count <= '0;
              state <= S_IDLE;
            end
          end
        end
        S_PICK: begin
          if (settled) begin
            settle <= '0;
            if (chain[MAX_PROCESSES].best_ok) begin
              cur_time <= cur_time + {8'd0, chain[MAX_PROCESSES].best_burst};
              result_valid <= 1'b1;
              result.job_index <= 4'(chain[MAX_PROCESSES].best_idx);
              result.completion_time <=
                cur_time + {8'd0, chain[MAX_PROCESSES].best_burst};
              result.last_result <= (picked + 1'b1 == count);
              picked <= picked + 1'b1;
              if (picked + 1'b1 == count) begin
                count <= '0;
                state <= S_IDLE;
              end
            end else begin
              // nothing ready: jump to the next arrival
              cur_time <= {8'd0, chain[MAX_PROCESSES].min_arr};
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
